// File: design/bounded_newest_first_list_top_macros.svh
// ----------------------------------------------------------------------------
// Bounded newest-first list assertion macros
// Shorthand for clocked concurrent checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_NEWEST_FIRST_LIST_TOP_MACROS_SVH
`define BOUNDED_NEWEST_FIRST_LIST_TOP_MACROS_SVH

// expression holds at every edge out of reset
`define BNFL_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define BNFL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bnfl_pkg.sv
// ----------------------------------------------------------------------------
// Bounded newest-first list package
// Shared widths, codes and item types for the sorted key list.
// ----------------------------------------------------------------------------
package bnfl_pkg;

	localparam int unsigned CAPACITY_DEF = 10;
	localparam int unsigned KEY_W        = 20;
	localparam int unsigned POS_W        = 6;
	localparam int unsigned CNT_W        = 7;
	localparam logic [KEY_W-1:0] NUMBER_WRAP = KEY_W'(1000000);

	typedef enum logic [2:0] {
		REQ_CLEAR  = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_TAKE   = 3'd2,
		REQ_READ   = 3'd3,
		REQ_REMOVE = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_EXEC
	} state_t;

	typedef struct packed {
		req_t             req_type;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] result_key;
		logic             dropped_valid;
		logic [KEY_W-1:0] dropped_key;
		logic [CNT_W-1:0] entries;
	} out_item_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [KEY_W-1:0] k;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

	typedef struct packed {
		logic             found;
		logic             reject;
		logic [KEY_W-1:0] last_key;
		logic [KEY_W-1:0] read_key;
	} cell_stat_t;

endpackage

// File: design/bnfl_cell.sv
// ----------------------------------------------------------------------------
// Bounded newest-first list cell
// Holds one key; shifts toward the tail on insert, toward the head on remove.
// ----------------------------------------------------------------------------
module bnfl_cell import bnfl_pkg::*; (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic             valid,
	input  logic             found,
	input  logic             prev_gt,
	input  logic [KEY_W-1:0] prev_key,
	input  logic [KEY_W-1:0] next_key,
	output logic             gt,
	output logic             eq,
	output logic [KEY_W-1:0] key
);

	logic [KEY_W-1:0] key_q;

	assign gt  = valid && (key_q > cmd.k);
	assign eq  = valid && (key_q == cmd.k);
	assign key = key_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && !gt) begin
			key_q <= prev_gt ? cmd.k : prev_key;
		end else if (cmd.rem && found && valid && (key_q <= cmd.k)) begin
			key_q <= next_key;
		end
	end

endmodule

// File: design/bnfl_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded newest-first list control
// Request sequencer, entry count, number counter and result register.
// ----------------------------------------------------------------------------
`include "bounded_newest_first_list_top_macros.svh"

module bnfl_ctrl import bnfl_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_item_t         request,
	output logic             done,
	output out_item_t        result,
	output cell_cmd_t        cmd,
	output logic [CNT_W-1:0] count,
	input  cell_stat_t       stat
);

	state_t           state_q, state_d;
	req_t             req_q;
	logic [KEY_W-1:0] key_q;
	logic [POS_W-1:0] pos_q;
	logic [KEY_W-1:0] k_q, k_d;
	logic [KEY_W-1:0] next_q, next_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             done_q;
	out_item_t        rsp_q, rsp_d;
	logic             full;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;
	assign count  = cnt_q;
	assign full   = (cnt_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			next_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			next_q  <= next_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= request.req_type;
			key_q <= request.key;
			pos_q <= request.position;
		end
		if (state_q == ST_PREP) begin
			k_q <= k_d;
		end
		if (state_q == ST_EXEC) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_PREP;
			ST_PREP: state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// operand and number counter
	always_comb begin
		k_d    = key_q;
		next_d = next_q;
		if (state_q == ST_PREP) begin
			case (req_q)
				REQ_CLEAR: next_d = '0;
				REQ_INSERT: begin
					if (key_q >= next_q) next_d = key_q + KEY_W'(1);
				end
				REQ_TAKE: begin
					k_d    = (next_q >= NUMBER_WRAP) ? (next_q - NUMBER_WRAP) : next_q;
					next_d = next_q + KEY_W'(1);
				end
				default: next_d = next_q;
			endcase
		end
	end

	always_comb begin
		cmd.ins = (state_q == ST_EXEC) && ((req_q == REQ_INSERT) || (req_q == REQ_TAKE));
		cmd.rem = (state_q == ST_EXEC) && (req_q == REQ_REMOVE);
		cmd.k   = k_q;
		cmd.pos = pos_q;
	end

	always_comb begin
		rsp_d = '0;
		cnt_d = cnt_q;
		if (state_q == ST_EXEC) begin
			case (req_q)
				REQ_CLEAR: begin
					rsp_d.ok = 1'b1;
					cnt_d    = '0;
				end
				REQ_INSERT, REQ_TAKE: begin
					rsp_d.ok = 1'b1;
					if (req_q == REQ_TAKE) rsp_d.result_key = k_q;
					if (full) begin
						rsp_d.dropped_valid = 1'b1;
						rsp_d.dropped_key   = stat.reject ? k_q : stat.last_key;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
				REQ_READ: begin
					if (CNT_W'(pos_q) < cnt_q) begin
						rsp_d.ok         = 1'b1;
						rsp_d.result_key = stat.read_key;
					end
				end
				REQ_REMOVE: begin
					if (stat.found) begin
						rsp_d.ok = 1'b1;
						cnt_d    = cnt_q - CNT_W'(1);
					end
				end
				default: rsp_d.ok = 1'b0;
			endcase
			rsp_d.entries = cnt_d;
		end
	end

	`BNFL_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`BNFL_ASSERT_ALWAYS(a_done_after_exec, !done_q || $past(state_q == ST_EXEC), "stray done")
	`BNFL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not set busy")
	`BNFL_ASSERT_ALWAYS(a_drop_ok, !done_q || !rsp_q.dropped_valid || rsp_q.ok, "drop without ok")

endmodule

// File: design/bounded_newest_first_list_top.sv
// ----------------------------------------------------------------------------
// Bounded newest-first list
// Sorted key list, largest first, kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// After the accepting edge an item runs through the prepare and cell update states; done then pulses.
// A new item is accepted only while idle; busy covers the prepare and cell update states.
// Insert and remove shift all affected cells at the same edge; the row length does not change item timing.
// Reset clears the entry count, the number counter and the sequencer; keys are not cleared.
// Results are flagged by done for one cycle and cannot be stalled.
module bounded_newest_first_list_top import bnfl_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      done,
	output out_item_t result
);

	cell_cmd_t        cmd;
	cell_stat_t       stat;
	logic [CNT_W-1:0] count;
	logic             gt    [CAPACITY];
	logic             eq    [CAPACITY];
	logic [KEY_W-1:0] keys  [CAPACITY];
	logic [KEY_W-1:0] picks [CAPACITY];
	logic [CAPACITY-1:0] eq_vec;

	bnfl_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result),
		.cmd     (cmd),
		.count   (count),
		.stat    (stat)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bnfl_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.valid    (count > CNT_W'(i)),
			.found    (stat.found),
			.prev_gt  ((i == 0) ? 1'b1 : gt[(i == 0) ? 0 : i-1]),
			.prev_key (keys[(i == 0) ? 0 : i-1]),
			.next_key (keys[(i == CAPACITY-1) ? i : i+1]),
			.gt       (gt[i]),
			.eq       (eq[i]),
			.key      (keys[i])
		);
		assign eq_vec[i] = eq[i];
		assign picks[i]  = (cmd.pos == POS_W'(i)) ? keys[i] : '0;
	end

	always_comb begin
		stat.read_key = '0;
		for (int unsigned j = 0; j < CAPACITY; j++) begin
			stat.read_key = stat.read_key | picks[j];
		end
		stat.found    = |eq_vec;
		stat.reject   = gt[CAPACITY-1];
		stat.last_key = keys[CAPACITY-1];
	end

endmodule
